/* rtl/k2t_pkg.sv */
// ----------------------------------------------------------------------------
// k2t_pkg
// Shared types and codes for the k2-tree edge store: datapath operations,
// controller status and result codes.
// ----------------------------------------------------------------------------
package k2t_pkg;

	// width of level and side counters
	localparam int LVL_W = 5;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BEYOND = 2'd2;

	// command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_TEST   = 1'b1;

	// one datapath operation per cycle
	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_ST_BEYOND,
		OP_ST_FULL,
		OP_GROW,
		OP_SWEEP_INIT,
		OP_SWEEP,
		OP_DRAIN,
		OP_ADVANCE,
		OP_MARK,
		OP_LEAF_SET,
		OP_PRESENT,
		OP_SH_INIT,
		OP_SHIFT,
		OP_ZERO,
		OP_ROOT_SET
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic beyond;
		logic full;
		logic outside;
		logic is_test;
		logic any_ones;
		logic leaf;
		logic bit_set;
		logic sweep_last;
		logic shift_done;
		logic zero_done;
	} stat_t;

endpackage

/* rtl/k2_tree_edge_insert_and_query_top.sv */
// ----------------------------------------------------------------------------
// k2_tree_edge_insert_and_query_top
// Edge store for a binary adjacency matrix kept as a dynamic k2-tree (k = 2).
// ----------------------------------------------------------------------------
// Usage:
//  - an item (command, row_coord, col_coord) is taken when start is high and
//    busy is low; command 0 inserts the edge, 1 tests it
//  - one result beat per item: present and status are valid for the single
//    cycle in which done is high; the receiver has no backpressure
//  - each level costs a rank sweep over the bit memory and a decision; an
//    insert that opens a new child block also shifts the tail, as does every
//    root prepend on growth
//  - the sweeps and shifts are bounded by the single read and single write
//    port of the bit memory; a rejected or out-of-range item shows its result
//    beat straight after the check state
//  - one item at a time: busy stays high until the done beat has been shown
//  - after reset the first four tree bits are cleared with busy high; the
//    tree is then empty with matrix side 2
// ----------------------------------------------------------------------------
module k2_tree_edge_insert_and_query_top #(
	parameter int MAX_BITS   = 4096,
	parameter int MAX_LEVELS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [15:0] row_coord,
	input  logic [15:0] col_coord,
	output logic        done,
	output logic        present,
	output logic [1:0]  status
);

	k2t_pkg::cmd_t  cmd;
	k2t_pkg::stat_t stat;

	// sequencer
	k2t_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd),
		.stat  (stat)
	);

	// datapath and bit memory
	k2t_dp #(.MAX_BITS(MAX_BITS), .MAX_LEVELS(MAX_LEVELS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.command  (command),
		.row_coord(row_coord),
		.col_coord(col_coord),
		.cmd      (cmd),
		.stat     (stat),
		.present  (present),
		.status   (status)
	);

endmodule

/* rtl/k2t_ram.sv */
// ----------------------------------------------------------------------------
// k2t_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module k2t_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/k2t_ctrl.sv */
// ----------------------------------------------------------------------------
// k2t_ctrl
// Sequencer for the k2-tree store: walks levels, rank sweeps, tail shifts and
// root growth, issuing one datapath operation per cycle.
// ----------------------------------------------------------------------------
module k2t_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	output k2t_pkg::cmd_t   cmd,
	input  k2t_pkg::stat_t  stat
);

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CHECK,
		S_GROW,
		S_GROW_CHK,
		S_LVL,
		S_SWEEP,
		S_DRAIN,
		S_DECIDE,
		S_SH_INIT,
		S_SHIFT,
		S_ZERO,
		S_ROOT,
		S_RESP
	} state_t;

	state_t state_q, state_d;
	logic   from_grow_q, from_grow_d;
	logic   done_q;

	// next state and operation
	always_comb begin
		state_d     = state_q;
		from_grow_d = from_grow_q;
		cmd.op      = k2t_pkg::OP_NONE;
		unique case (state_q)
			S_INIT: begin
				cmd.op = k2t_pkg::OP_CLEAR;
				if (stat.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.op  = k2t_pkg::OP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				priority if (stat.beyond) begin
					cmd.op  = k2t_pkg::OP_ST_BEYOND;
					state_d = S_RESP;
				end else if (stat.is_test) begin
					state_d = stat.outside ? S_RESP : S_LVL;
				end else if (stat.full) begin
					cmd.op  = k2t_pkg::OP_ST_FULL;
					state_d = S_RESP;
				end else begin
					state_d = stat.outside ? S_GROW : S_LVL;
				end
			end
			S_GROW: begin
				cmd.op = k2t_pkg::OP_GROW;
				if (stat.any_ones) begin
					from_grow_d = 1'b1;
					state_d     = S_SH_INIT;
				end else begin
					state_d = S_GROW_CHK;
				end
			end
			S_GROW_CHK: begin
				state_d = stat.outside ? S_GROW : S_LVL;
			end
			S_LVL: begin
				cmd.op  = k2t_pkg::OP_SWEEP_INIT;
				state_d = S_SWEEP;
			end
			S_SWEEP: begin
				cmd.op = k2t_pkg::OP_SWEEP;
				if (stat.sweep_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				cmd.op  = k2t_pkg::OP_DRAIN;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				priority if (stat.leaf) begin
					cmd.op  = stat.is_test ? k2t_pkg::OP_PRESENT : k2t_pkg::OP_LEAF_SET;
					state_d = S_RESP;
				end else if (stat.bit_set) begin
					cmd.op  = k2t_pkg::OP_ADVANCE;
					state_d = S_LVL;
				end else if (stat.is_test) begin
					state_d = S_RESP;
				end else begin
					cmd.op      = k2t_pkg::OP_MARK;
					from_grow_d = 1'b0;
					state_d     = S_SH_INIT;
				end
			end
			S_SH_INIT: begin
				cmd.op  = k2t_pkg::OP_SH_INIT;
				state_d = S_SHIFT;
			end
			S_SHIFT: begin
				cmd.op = k2t_pkg::OP_SHIFT;
				if (stat.shift_done) state_d = S_ZERO;
			end
			S_ZERO: begin
				cmd.op = k2t_pkg::OP_ZERO;
				if (stat.zero_done) state_d = from_grow_q ? S_ROOT : S_LVL;
			end
			S_ROOT: begin
				cmd.op  = k2t_pkg::OP_ROOT_SET;
				state_d = S_GROW_CHK;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and registered strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			from_grow_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			from_grow_q <= from_grow_d;
			done_q      <= (state_d == S_RESP);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

/* rtl/k2t_dp.sv */
// ----------------------------------------------------------------------------
// k2t_dp
// Datapath for the k2-tree store: item registers, tree bit memory, rank
// counter, tail shifter and result registers.
// ----------------------------------------------------------------------------
module k2t_dp #(
	parameter int MAX_BITS   = 4096,
	parameter int MAX_LEVELS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            command,
	input  logic [15:0]     row_coord,
	input  logic [15:0]     col_coord,
	input  k2t_pkg::cmd_t   cmd,
	output k2t_pkg::stat_t  stat,
	output logic            present,
	output logic [1:0]      status
);

	localparam int AW  = $clog2(MAX_BITS);
	localparam int BCW = $clog2(MAX_BITS + 1);
	localparam int PW  = BCW + 3;
	localparam int LW  = k2t_pkg::LVL_W;

	// control state
	logic [BCW-1:0] bc_q;
	logic [LW-1:0]  side_q;
	logic           any_q;
	logic [1:0]     zc_q;
	logic           rd_valid_q;

	// item and walk registers
	logic           cmd_q;
	logic [15:0]    row_q, col_q;
	logic [LW-1:0]  lvl_q;
	logic [PW-1:0]  pos_q, p_q;
	logic [BCW-1:0] ins_q, idx_q, cnt_q, rd_addr_q;
	logic           bit_q;
	logic           present_q;
	logic [1:0]     status_q;

	// memory port
	logic           we;
	logic [AW-1:0]  waddr, raddr;
	logic           wdata, rdata;

	logic [31:0]    row_sh, col_sh;
	logic [1:0]     quad;
	logic [PW-1:0]  bc_ext, next_pos;
	logic           p_in;
	logic [BCW-1:0] sweep_end, mark_ins, cnt_acc;
	logic           bit_acc;

	k2t_ram #(.WIDTH(1), .DEPTH(MAX_BITS)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// quadrant of the current level and child block position
	assign row_sh    = 32'(row_q) >> (lvl_q - LW'(1));
	assign col_sh    = 32'(col_q) >> (lvl_q - LW'(1));
	assign quad      = {row_sh[0], col_sh[0]};
	assign bc_ext    = PW'(bc_q);
	assign p_in      = (p_q < bc_ext);
	assign sweep_end = p_in ? BCW'(p_q) : (bc_q - BCW'(1));
	assign next_pos  = PW'({cnt_q, 2'b00}) + PW'(4);
	assign mark_ins  = (next_pos > bc_ext) ? bc_q : BCW'(next_pos);

	// rank accumulation of the read beat that has just returned
	always_comb begin
		cnt_acc = cnt_q;
		bit_acc = bit_q;
		if (rd_valid_q) begin
			if (PW'(rd_addr_q) < p_q) cnt_acc = cnt_q + BCW'(rdata);
			if (PW'(rd_addr_q) == p_q) bit_acc = rdata;
		end
	end

	// status to the controller
	always_comb begin
		stat.clr_done   = (zc_q == 2'd3);
		stat.beyond     = ((32'(row_q) >> MAX_LEVELS) != 32'd0) ||
		                  ((32'(col_q) >> MAX_LEVELS) != 32'd0);
		stat.full       = (32'(bc_q) + 32'(4 * MAX_LEVELS)) > 32'(MAX_BITS);
		stat.outside    = ((32'(row_q) >> side_q) != 32'd0) ||
		                  ((32'(col_q) >> side_q) != 32'd0);
		stat.is_test    = (cmd_q == k2t_pkg::CMD_TEST);
		stat.any_ones   = any_q;
		stat.leaf       = (lvl_q == LW'(1));
		stat.bit_set    = bit_q;
		stat.sweep_last = (idx_q == sweep_end);
		stat.shift_done = (idx_q <= ins_q) && !rd_valid_q;
		stat.zero_done  = (zc_q == 2'd3);
	end

	// memory write and read addresses
	always_comb begin
		we    = 1'b0;
		waddr = AW'(idx_q);
		wdata = 1'b0;
		unique case (cmd.op)
			k2t_pkg::OP_CLEAR: begin
				we    = 1'b1;
				waddr = AW'(zc_q);
			end
			k2t_pkg::OP_MARK, k2t_pkg::OP_LEAF_SET: begin
				we    = p_in;
				waddr = AW'(p_q);
				wdata = 1'b1;
			end
			k2t_pkg::OP_SHIFT: begin
				we    = rd_valid_q;
				waddr = AW'(rd_addr_q + BCW'(4));
				wdata = rdata;
			end
			k2t_pkg::OP_ZERO: begin
				we    = 1'b1;
				waddr = AW'(ins_q + BCW'(zc_q));
			end
			k2t_pkg::OP_ROOT_SET: begin
				we    = 1'b1;
				waddr = '0;
				wdata = 1'b1;
			end
			default: ;
		endcase
		raddr = (cmd.op == k2t_pkg::OP_SHIFT) ? AW'(idx_q - BCW'(1)) : AW'(idx_q);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q       <= BCW'(4);
			side_q     <= LW'(1);
			any_q      <= 1'b0;
			zc_q       <= 2'd0;
			rd_valid_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				k2t_pkg::OP_CLEAR:      zc_q <= zc_q + 2'd1;
				k2t_pkg::OP_GROW:       side_q <= side_q + LW'(1);
				k2t_pkg::OP_SWEEP_INIT: rd_valid_q <= 1'b0;
				k2t_pkg::OP_SWEEP:      rd_valid_q <= 1'b1;
				k2t_pkg::OP_DRAIN:      rd_valid_q <= 1'b0;
				k2t_pkg::OP_LEAF_SET:   any_q <= 1'b1;
				k2t_pkg::OP_SH_INIT: begin
					rd_valid_q <= 1'b0;
					zc_q       <= 2'd0;
				end
				k2t_pkg::OP_SHIFT:      rd_valid_q <= (idx_q > ins_q);
				k2t_pkg::OP_ZERO: begin
					zc_q <= zc_q + 2'd1;
					if (zc_q == 2'd3) bc_q <= bc_q + BCW'(4);
				end
				default: ;
			endcase
		end
	end

	// walk and result registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			k2t_pkg::OP_LOAD: begin
				cmd_q     <= command;
				row_q     <= row_coord;
				col_q     <= col_coord;
				pos_q     <= '0;
				lvl_q     <= side_q;
				present_q <= 1'b0;
				status_q  <= k2t_pkg::ST_OK;
			end
			k2t_pkg::OP_ST_BEYOND: status_q <= k2t_pkg::ST_BEYOND;
			k2t_pkg::OP_ST_FULL:   status_q <= k2t_pkg::ST_FULL;
			k2t_pkg::OP_GROW: begin
				lvl_q <= side_q + LW'(1);
				ins_q <= '0;
			end
			k2t_pkg::OP_SWEEP_INIT: begin
				p_q   <= pos_q + PW'(quad);
				idx_q <= '0;
				cnt_q <= '0;
				bit_q <= 1'b0;
			end
			k2t_pkg::OP_SWEEP: begin
				cnt_q     <= cnt_acc;
				bit_q     <= bit_acc;
				rd_addr_q <= idx_q;
				idx_q     <= idx_q + BCW'(1);
			end
			k2t_pkg::OP_DRAIN: begin
				cnt_q <= cnt_acc;
				bit_q <= bit_acc;
			end
			k2t_pkg::OP_ADVANCE: begin
				pos_q <= next_pos;
				lvl_q <= lvl_q - LW'(1);
			end
			k2t_pkg::OP_MARK: begin
				pos_q <= PW'(mark_ins);
				ins_q <= mark_ins;
				lvl_q <= lvl_q - LW'(1);
			end
			k2t_pkg::OP_PRESENT:  present_q <= bit_q;
			k2t_pkg::OP_SH_INIT:  idx_q <= bc_q;
			k2t_pkg::OP_SHIFT: begin
				if (idx_q > ins_q) begin
					rd_addr_q <= idx_q - BCW'(1);
					idx_q     <= idx_q - BCW'(1);
				end
			end
			default: ;
		endcase
	end

	assign present = present_q;
	assign status  = status_q;

endmodule

/* rtl/k2t_chk.sv */
// ----------------------------------------------------------------------------
// k2t_chk
// Port-level checks for the k2-tree edge store, bound to the top level.
// ----------------------------------------------------------------------------
module k2t_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       present,
	input logic [1:0] status
);

	// a result beat only comes while an item is held
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done without busy");

	// the block frees up right after the result beat
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after result beat");

	// an accepted item holds the block busy
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("item taken but not busy");

	// a present edge is only reported on a clean result
	a_present_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && present) |-> (status == k2t_pkg::ST_OK))
		else $error("present with bad status");

	// status code is never the unused code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= k2t_pkg::ST_BEYOND)) else $error("undefined status code");

endmodule

bind k2_tree_edge_insert_and_query_top k2t_chk u_chk (.*);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the k2-tree edge store. Edge inserts and edge tests
// go in one beat at a time; an in-bench copy of the tree predicts each result
// beat, which is compared field by field in order of issue. Most edges are
// kept inside a small matrix so the bit store stays short and latency low; a
// closing phase drives full-range inserts until three have been refused as full.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int NBITS      = 4096;
	localparam int NLEVELS    = 16;
	localparam int IDLE_LIMIT = 1000000;

	typedef struct packed {
		logic       present;
		logic [1:0] status;
	} edge_result_t;

	// ------------------------------------------------------------------------
	// scoreboard: holds its own copy of the tree and the expected results
	// ------------------------------------------------------------------------
	class edge_scoreboard;
		bit           tree[NBITS];
		int unsigned  nbits;
		int unsigned  side_lg;
		edge_result_t awaited[$];
		int           errors;
		int           n_ins, n_test, n_full, n_hit, n_checked;

		function new();
			nbits   = 4;
			side_lg = 1;
			foreach (tree[i]) tree[i] = 1'b0;
		endfunction

		function bit rd(int unsigned p);
			return (p >= nbits) ? 1'b0 : tree[p];
		endfunction

		// ones in [0, n)
		function int unsigned ones_below(int unsigned n);
			int unsigned c;
			c = 0;
			if (n > nbits) n = nbits;
			for (int unsigned i = 0; i < n; i++) c += tree[i];
			return c;
		endfunction

		// open a block of four zero bits at p
		function void open_block(int unsigned p);
			if (p > nbits) p = nbits;
			for (int i = int'(nbits) - 1; i >= int'(p); i--) tree[i + 4] = tree[i];
			for (int i = 0; i < 4; i++) tree[p + i] = 1'b0;
			nbits += 4;
		endfunction

		function int unsigned quad(int unsigned r, int unsigned c, int unsigned lvl);
			return (((r >> (lvl - 1)) & 1) << 1) | ((c >> (lvl - 1)) & 1);
		endfunction

		function void add_edge(int unsigned r, int unsigned c);
			int unsigned pos, q;
			pos = 0;
			// grow side, new root only when tree holds a one
			while ((r >> side_lg) != 0 || (c >> side_lg) != 0) begin
				side_lg++;
				if (ones_below(nbits) != 0) begin
					open_block(0);
					tree[0] = 1'b1;
				end
			end
			for (int unsigned lvl = side_lg; lvl > 1; lvl--) begin
				q = quad(r, c, lvl);
				pos += q;
				if (rd(pos)) begin
					pos = (ones_below(pos) + 1) * 4;
				end else begin
					if (pos < nbits) tree[pos] = 1'b1;
					pos = (ones_below(pos) + 1) * 4;
					if (pos > nbits) pos = nbits;
					open_block(pos);
				end
			end
			q = quad(r, c, 1);
			if (pos + q < nbits) tree[pos + q] = 1'b1;
		endfunction

		function bit has_edge(int unsigned r, int unsigned c);
			int unsigned pos, q;
			pos = 0;
			if ((r >> side_lg) != 0 || (c >> side_lg) != 0) return 1'b0;
			for (int unsigned lvl = side_lg; lvl > 1; lvl--) begin
				q = quad(r, c, lvl);
				pos += q;
				if (!rd(pos)) return 1'b0;
				pos = ones_below(pos + 1) * 4;
			end
			return rd(pos + quad(r, c, 1));
		endfunction

		// accepted input beat: work out the result it must produce
		// (16-bit coordinates never reach the beyond-size limit of 2^16)
		function void note_item(logic cmd, logic [15:0] r, logic [15:0] c);
			edge_result_t e;
			e.present = 1'b0;
			e.status  = k2t_pkg::ST_OK;
			if ((int'(r) >> NLEVELS) != 0 || (int'(c) >> NLEVELS) != 0) begin
				e.status = k2t_pkg::ST_BEYOND;
			end else if (cmd == k2t_pkg::CMD_INSERT) begin
				n_ins++;
				if (nbits + 4 * NLEVELS > NBITS) begin
					e.status = k2t_pkg::ST_FULL;
					n_full++;
				end else begin
					add_edge(r, c);
				end
			end else begin
				n_test++;
				e.present = has_edge(r, c);
				n_hit += e.present;
			end
			awaited = {awaited, e};
		endfunction

		function void check_result(logic pres, logic [1:0] st);
			edge_result_t e;
			n_checked++;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result beat present=%0b status=%0d",
					$time, pres, st);
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (pres !== e.present) begin
				$display("%0t: present mismatch: expected %0b, actual %0b",
					$time, e.present, pres);
				errors++;
			end
			if (st !== e.status) begin
				$display("%0t: status mismatch: expected %0d, actual %0d",
					$time, e.status, st);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        command;
	logic [15:0] row_coord;
	logic [15:0] col_coord;
	logic        done;
	logic        present;
	logic [1:0]  status;

	edge_scoreboard sb;
	int             idle_cycles;
	logic [15:0]    stored_r[$];
	logic [15:0]    stored_c[$];
	bit             gaps_on;

	k2_tree_edge_insert_and_query_top #(
		.MAX_BITS   (NBITS),
		.MAX_LEVELS (NLEVELS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.row_coord (row_coord),
		.col_coord (col_coord),
		.done      (done),
		.present   (present),
		.status    (status)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(present, status);
	end

	// watchdog on cycles with no beat in either direction
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// one input beat, held until taken; optional idle burst afterwards
	task automatic send_item(logic cmd, logic [15:0] r, logic [15:0] c);
		int gap;
		start     <= 1'b1;
		command   <= cmd;
		row_coord <= r;
		col_coord <= c;
		do @(posedge clk); while (busy);
		sb.note_item(cmd, r, c);
		if (cmd == k2t_pkg::CMD_INSERT) begin
			stored_r = {stored_r, r};
			stored_c = {stored_c, c};
		end
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 17);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// test a previously inserted edge, or a near neighbour of one
	task automatic test_known(bit nudge);
		int k;
		logic [15:0] r, c;
		if (stored_r.size() == 0) begin
			send_item(k2t_pkg::CMD_TEST, 16'd0, 16'd0);
			return;
		end
		k = $urandom_range(0, stored_r.size() - 1);
		r = stored_r[k];
		c = stored_c[k];
		if (nudge) c = c ^ 16'(1 << $urandom_range(0, 3));
		send_item(k2t_pkg::CMD_TEST, r, c);
	endtask

	initial begin
		logic [15:0] r, c;
		int w;
		sb          = new();
		idle_cycles = 0;
		gaps_on     = 1'b0;
		arst_n      = 1'b0;
		start       = 1'b0;
		command     = k2t_pkg::CMD_INSERT;
		row_coord   = '0;
		col_coord   = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty tree, growth without root, outside matrix, extremes
		send_item(k2t_pkg::CMD_TEST,   16'd0,     16'd0);
		send_item(k2t_pkg::CMD_TEST,   16'd3,     16'd3);
		send_item(k2t_pkg::CMD_INSERT, 16'd2,     16'd3);
		send_item(k2t_pkg::CMD_TEST,   16'd2,     16'd3);
		send_item(k2t_pkg::CMD_TEST,   16'd3,     16'd2);
		send_item(k2t_pkg::CMD_INSERT, 16'd0,     16'd0);
		send_item(k2t_pkg::CMD_INSERT, 16'd0,     16'd0);
		send_item(k2t_pkg::CMD_TEST,   16'd0,     16'd0);
		send_item(k2t_pkg::CMD_TEST,   16'd9,     16'd1);
		send_item(k2t_pkg::CMD_INSERT, 16'd1,     16'd1);
		send_item(k2t_pkg::CMD_INSERT, 16'd65535, 16'd65535);
		send_item(k2t_pkg::CMD_TEST,   16'd65535, 16'd65535);
		send_item(k2t_pkg::CMD_TEST,   16'd65535, 16'd0);
		send_item(k2t_pkg::CMD_TEST,   16'd2,     16'd3);
		send_item(k2t_pkg::CMD_INSERT, 16'd0,     16'd65535);
		send_item(k2t_pkg::CMD_INSERT, 16'd65535, 16'd0);
		send_item(k2t_pkg::CMD_TEST,   16'd0,     16'd65535);
		send_item(k2t_pkg::CMD_TEST,   16'd65535, 16'd0);
		send_item(k2t_pkg::CMD_TEST,   16'd32768, 16'd32768);
		send_item(k2t_pkg::CMD_TEST,   16'd1,     16'd1);

		// random, small matrix; idle bursts switched per block of beats
		for (int i = 0; i < 200; i++) begin
			if (i % 40 == 0) gaps_on = $urandom_range(0, 1);
			case ($urandom_range(0, 3))
				0, 1: begin
					w = $urandom_range(1, 5);
					r = 16'($urandom & ((1 << w) - 1));
					c = 16'($urandom & ((1 << w) - 1));
					send_item(k2t_pkg::CMD_INSERT, r, c);
				end
				2: test_known($urandom_range(0, 1));
				default: begin
					w = $urandom_range(1, 6);
					r = 16'($urandom & ((1 << w) - 1));
					c = 16'($urandom & ((1 << w) - 1));
					send_item(k2t_pkg::CMD_TEST, r, c);
				end
			endcase
		end

		// a few full-range items
		gaps_on = 1'b1;
		for (int i = 0; i < 10; i++) begin
			send_item(($urandom_range(0, 1) ? k2t_pkg::CMD_TEST : k2t_pkg::CMD_INSERT),
				16'($urandom), 16'($urandom));
		end

		// closing phase, no idling: fill the bit store until it refuses
		gaps_on = 1'b0;
		while (sb.n_full < 3) begin
			send_item(k2t_pkg::CMD_INSERT, 16'($urandom), 16'($urandom));
			if ($urandom_range(0, 3) == 0) test_known(1'b0);
		end
		for (int i = 0; i < 6; i++) test_known(i[0]);
		start <= 1'b0;

		// drain
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d inserts (%0d refused as full), %0d tests (%0d found)",
			sb.n_ins, sb.n_full, sb.n_test, sb.n_hit);
		$display("%0d result beats checked, final tree %0d bits, side 2^%0d",
			sb.n_checked, sb.nbits, sb.side_lg);
		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
